// ===== hw/rtl/bdar_pkg.sv =====
// ----------------------------------------------------------------------------
// bdar_pkg: shared types and constants for the button debounce block
// Register indexes, field widths and the reset values of the configuration.
// ----------------------------------------------------------------------------
package bdar_pkg;

    // Field widths
    localparam int unsigned PIN_COUNT  = 4;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    typedef logic [PIN_COUNT-1:0] t_pins;
    typedef logic [TIME_W-1:0]    t_time;
    typedef logic [CFG_W-1:0]     t_cfg_data;
    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    // Configuration register indexes
    localparam t_cfg_index REG_DEBOUNCE_TIME = 2'd0;
    localparam t_cfg_index REG_START_DELAY   = 2'd1;
    localparam t_cfg_index REG_REPEAT_PERIOD = 2'd2;
    localparam t_cfg_index REG_REPEAT_MASK   = 2'd3;

    // Reset values of the configuration registers
    localparam t_cfg_data DEBOUNCE_TIME_RST = 16'd25;
    localparam t_cfg_data START_DELAY_RST   = 16'd500;
    localparam t_cfg_data REPEAT_PERIOD_RST = 16'd150;
    localparam t_pins     REPEAT_MASK_RST   = 4'd7;

endpackage

// ===== hw/rtl/button_debounce_auto_repeat_unit.sv =====
// ----------------------------------------------------------------------------
// button_debounce_auto_repeat_unit: debounce with auto-repeat per button
// Each poll word updates every button's debounce timer and repeat schedule
// and yields one word of press/repeat event bits.
// ----------------------------------------------------------------------------
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+--------------------------------
//  input   | i_in_valid  | o_in_stall  | i_pin_levels, i_now_ms
//  output  | o_out_valid | i_out_stall | o_events
//  config  | i_cfg_wr_en | (none)      | i_cfg_index, i_cfg_data
//
//  One poll word per cycle while the output is not stalled; an accepted word
//  reaches the output through the input register, then the result register.
//  All per-button state updates in the logic between those registers.
//  Reset (synchronous, active low) clears state and loads default settings.
//  A stalled output holds its word; the input register still refills while
//  the result register is free or being drained.
// ----------------------------------------------------------------------------
module button_debounce_auto_repeat_unit #(
    parameter int unsigned BUTTON_COUNT = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // poll words
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  bdar_pkg::t_pins       i_pin_levels,
    input  bdar_pkg::t_time       i_now_ms,
    // event words
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output bdar_pkg::t_pins       o_events,
    // configuration writes
    input  logic                  i_cfg_wr_en,
    input  bdar_pkg::t_cfg_index  i_cfg_index,
    input  bdar_pkg::t_cfg_data   i_cfg_data
);
    import bdar_pkg::*;

    // Configuration registers
    t_cfg_data r_debounce_time;
    t_cfg_data r_start_delay;
    t_cfg_data r_repeat_period;
    t_pins     r_repeat_mask;

    // Input register
    logic  r_in_valid;
    t_pins r_in_levels;
    t_time r_in_now;

    // Result register
    logic  r_out_valid;
    t_pins r_events;

    // Per-button state and next values
    logic [BUTTON_COUNT-1:0] r_stable;
    logic [BUTTON_COUNT-1:0] r_last_raw;
    t_time                   r_change_time [BUTTON_COUNT];
    t_time                   r_due_time    [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] n_stable;
    logic [BUTTON_COUNT-1:0] n_last_raw;
    t_time                   n_change_time [BUTTON_COUNT];
    t_time                   n_due_time    [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] w_ev;
    t_pins                   w_ev_out;
    t_pins                   w_stable_out;

    logic w_out_free;
    logic w_fire;

    // Flow control: the result register frees when empty or drained
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_fire      = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_events    = r_events;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time <= DEBOUNCE_TIME_RST;
            r_start_delay   <= START_DELAY_RST;
            r_repeat_period <= REPEAT_PERIOD_RST;
            r_repeat_mask   <= REPEAT_MASK_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE_TIME: r_debounce_time <= i_cfg_data;
                REG_START_DELAY:   r_start_delay   <= i_cfg_data;
                REG_REPEAT_PERIOD: r_repeat_period <= i_cfg_data;
                REG_REPEAT_MASK:   r_repeat_mask   <= i_cfg_data[PIN_COUNT-1:0];
                default: ;
            endcase
        end
    end

    // Capture a poll word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || w_out_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_levels <= i_pin_levels;
            r_in_now    <= i_now_ms;
        end
    end

    // Per-button debounce and repeat update
    for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_button
        logic w_raw;
        logic w_can_rep;

        // Buttons past the pin field read as pressed and never repeat
        if (b < PIN_COUNT) begin : g_pin
            assign w_raw     = ~r_in_levels[b];
            assign w_can_rep = r_repeat_mask[b];
        end else begin : g_nopin
            assign w_raw     = 1'b1;
            assign w_can_rep = 1'b0;
        end

        always_comb begin
            t_time elapsed;
            t_time since_due;
            logic  fresh;
            logic  due;
            elapsed            = r_in_now - r_change_time[b];
            since_due          = r_in_now - r_due_time[b];
            fresh              = 1'b0;
            n_stable[b]        = r_stable[b];
            n_last_raw[b]      = r_last_raw[b];
            n_change_time[b]   = r_change_time[b];
            n_due_time[b]      = r_due_time[b];
            w_ev[b]            = 1'b0;

            // Restart the timer on a raw change, else accept a settled level
            if (w_raw != r_last_raw[b]) begin
                n_last_raw[b]    = w_raw;
                n_change_time[b] = r_in_now;
            end else if (elapsed >= {{(TIME_W-CFG_W){1'b0}}, r_debounce_time}
                         && w_raw != r_stable[b]) begin
                n_stable[b] = w_raw;
                if (w_raw) begin
                    fresh         = 1'b1;
                    w_ev[b]       = 1'b1;
                    n_due_time[b] = r_in_now + {{(TIME_W-CFG_W){1'b0}}, r_start_delay};
                end
            end

            // A fresh press is due at once only with a zero start delay
            if (fresh) begin
                due = (r_start_delay == '0);
            end else begin
                due = !since_due[TIME_W-1];
            end

            // Fire a repeat and reschedule it
            if (n_stable[b] && w_can_rep && due) begin
                w_ev[b]       = 1'b1;
                n_due_time[b] = r_in_now + {{(TIME_W-CFG_W){1'b0}}, r_repeat_period};
            end
        end
    end

    // Map button events and states onto the pin-wide field
    for (genvar j = 0; j < PIN_COUNT; j++) begin : g_out_bit
        if (j < BUTTON_COUNT) begin : g_live
            assign w_ev_out[j]     = w_ev[j];
            assign w_stable_out[j] = r_stable[j];
        end else begin : g_dead
            assign w_ev_out[j]     = 1'b0;
            assign w_stable_out[j] = 1'b0;
        end
    end

    // Commit button state when a word moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable   <= '0;
            r_last_raw <= '0;
            for (int b = 0; b < BUTTON_COUNT; b++) begin
                r_change_time[b] <= '0;
                r_due_time[b]    <= '0;
            end
        end else if (w_fire) begin
            r_stable   <= n_stable;
            r_last_raw <= n_last_raw;
            for (int b = 0; b < BUTTON_COUNT; b++) begin
                r_change_time[b] <= n_change_time[b];
                r_due_time[b]    <= n_due_time[b];
            end
        end
    end

    // Hold or advance the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_events <= w_ev_out;
        end
    end

`ifndef ASSERT_OFF
    // An event is only reported for a button that is now held down
    a_event_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> ((r_events & ~w_stable_out) == '0))
        else $error("event reported for a released button");

    // The input side stalls only with a word waiting in the input register
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stalled with an empty input register");

    // A processed word always lands in the result register
    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed word lost");

    // Button state changes only when a word is processed
    a_state_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> ($stable(r_stable) && $stable(r_last_raw)))
        else $error("button state changed without a word");
`endif

endmodule
